[hw/rtl/multi_channel_pipe_fifo_unit_assert.svh]
// assertion macros for the multi-channel pipe fifo unit
// expects i_clk and i_rst_n in the scope of use
`ifndef MULTI_CHANNEL_PIPE_FIFO_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_PIPE_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MCPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mcpf assertion failed");
`define MCPF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mcpf reset assertion failed");
`else
`define MCPF_ASSERT(lbl, prop)
`define MCPF_ASSERT_RST(lbl, prop)
`endif
`endif

[hw/rtl/mcpf_pkg.sv]
// shared types, constants and helpers of the multi-channel pipe fifo unit
// no dependencies
`default_nettype none

package mcpf_pkg;

    localparam int PIPE_COUNT = 8;
    localparam int RING_DEPTH = 256;

    localparam int ID_W   = 4;
    localparam int RID_W  = 3;
    localparam int PIPE_W = $clog2(PIPE_COUNT);
    localparam int CNT_W  = $clog2(PIPE_COUNT + 1);

    typedef enum logic [1:0] {
        MODE_OPEN  = 2'd0,
        MODE_CLOSE = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NO_END    = 3'd1,
        STAT_NO_PIPE   = 3'd2,
        STAT_BLOCK     = 3'd3,
        STAT_WRONG_DIR = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    function automatic logic [PIPE_W-1:0] pipe_of(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] w;
        w = id - ID_W'(PIPE_COUNT);
        if (id < ID_W'(PIPE_COUNT)) begin
            return id[PIPE_W-1:0];
        end
        return w[PIPE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mcpf_ctrl.sv]
// controller of the multi-channel pipe fifo unit: handshake and sequencing
// depends on mcpf_pkg and multi_channel_pipe_fifo_unit_assert.svh
`default_nettype none
`include "multi_channel_pipe_fifo_unit_assert.svh"

module mcpf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_valid,
    output logic             o_s_ready,
    input  wire              i_m_ready,
    output logic             o_m_valid,
    output mcpf_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load, commit;

    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                load = i_s_valid;
                if (i_s_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                commit = !r_out_valid || i_m_ready;
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready   = (r_state == ST_IDLE);
    assign o_m_valid   = r_out_valid;
    assign o_cmd.load   = load;
    assign o_cmd.commit = commit;

    `MCPF_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE) && !r_out_valid)
    `MCPF_ASSERT(a_accept_exec, load |=> (r_state == ST_EXEC))
    `MCPF_ASSERT(a_valid_from_commit, $rose(r_out_valid) |-> $past(commit))

endmodule

`default_nettype wire

[hw/rtl/mcpf_dp.sv]
// datapath of the multi-channel pipe fifo unit: pipe table, ring memory, result register
// depends on mcpf_pkg and multi_channel_pipe_fifo_unit_assert.svh
`default_nettype none
`include "multi_channel_pipe_fifo_unit_assert.svh"

module mcpf_dp #(
    parameter int RING_DEPTH = mcpf_pkg::RING_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mcpf_pkg::t_cmd               i_cmd,
    input  wire  [1:0]                   i_mode,
    input  wire  [mcpf_pkg::ID_W-1:0]    i_id,
    input  wire  [7:0]                   i_byte,
    input  wire                          i_last,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_rdata,
    output logic [mcpf_pkg::RID_W-1:0]   o_rid,
    output logic [mcpf_pkg::ID_W-1:0]    o_wid,
    output logic                         o_last
);

    localparam int NP     = mcpf_pkg::PIPE_COUNT;
    localparam int PIPE_W = mcpf_pkg::PIPE_W;
    localparam int CNT_W  = mcpf_pkg::CNT_W;
    localparam int ID_W   = mcpf_pkg::ID_W;
    localparam int RID_W  = mcpf_pkg::RID_W;
    localparam int PW     = $clog2(RING_DEPTH);
    localparam int FW     = $clog2(RING_DEPTH + 1);
    localparam int AW     = PIPE_W + PW;
    localparam int MEM_D  = NP * (2 ** PW);

    logic [NP-1:0]       r_rd_open, n_rd_open;
    logic [NP-1:0]       r_wr_open, n_wr_open;
    logic [CNT_W-1:0]    r_created, n_created;

    logic [PW-1:0]       r_rd_ptr [NP];
    logic [PW-1:0]       r_wr_ptr [NP];
    logic [FW-1:0]       r_fill   [NP];
    logic [7:0]          r_ring   [MEM_D];

    mcpf_pkg::t_mode     r_mode;
    logic [ID_W-1:0]     r_id;
    logic [7:0]          r_byte;
    logic                r_last;
    logic [PIPE_W-1:0]   r_pipe;
    logic [PW-1:0]       r_cur_rd;
    logic [PW-1:0]       r_cur_wr;
    logic [FW-1:0]       r_cur_fill;
    logic [7:0]          r_mem_q;

    logic [2:0]          r_out_status;
    logic [7:0]          r_out_rdata;
    logic [RID_W-1:0]    r_out_rid;
    logic [ID_W-1:0]     r_out_wid;
    logic                r_out_last;

    logic [PIPE_W-1:0]   in_pipe;
    logic                is_rd, in_range, created, usable;
    logic                free_found;
    logic [PIPE_W-1:0]   free_idx;
    logic [PIPE_W-1:0]   open_idx;
    mcpf_pkg::t_status   n_status;
    logic [7:0]          n_rdata;
    logic [RID_W-1:0]    n_rid;
    logic [ID_W-1:0]     n_wid;
    logic                do_open, do_write, do_read;
    logic [PW-1:0]       rd_next, wr_next;

    assign in_pipe  = mcpf_pkg::pipe_of(i_id);
    assign is_rd    = r_id < ID_W'(NP);
    assign in_range = {1'b0, r_id} < (ID_W + 1)'(2 * NP);
    assign created  = CNT_W'(r_pipe) < r_created;
    assign usable   = is_rd ? r_rd_open[r_pipe] : (in_range && r_wr_open[r_pipe]);
    assign rd_next  = (r_cur_rd == PW'(RING_DEPTH - 1)) ? '0 : r_cur_rd + PW'(1);
    assign wr_next  = (r_cur_wr == PW'(RING_DEPTH - 1)) ? '0 : r_cur_wr + PW'(1);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NP; i++) begin
            if (!free_found && CNT_W'(i) < r_created && !r_rd_open[i] && !r_wr_open[i]) begin
                free_found = 1'b1;
                free_idx   = PIPE_W'(i);
            end
        end
    end

    always_comb begin
        n_status  = mcpf_pkg::STAT_OK;
        n_rdata   = '0;
        n_rid     = '0;
        n_wid     = '0;
        n_rd_open = r_rd_open;
        n_wr_open = r_wr_open;
        n_created = r_created;
        do_open   = 1'b0;
        do_write  = 1'b0;
        do_read   = 1'b0;
        open_idx  = free_idx;
        case (r_mode)
            mcpf_pkg::MODE_OPEN: begin
                if (free_found) begin
                    do_open = 1'b1;
                end else if (r_created < CNT_W'(NP)) begin
                    do_open   = 1'b1;
                    open_idx  = r_created[PIPE_W-1:0];
                    n_created = r_created + CNT_W'(1);
                end else begin
                    n_status = mcpf_pkg::STAT_NO_PIPE;
                end
                if (do_open) begin
                    n_rd_open[open_idx] = 1'b1;
                    n_wr_open[open_idx] = 1'b1;
                    n_rid = RID_W'(open_idx);
                    n_wid = ID_W'(open_idx) + ID_W'(NP);
                end
            end
            mcpf_pkg::MODE_CLOSE: begin
                if (in_range && created) begin
                    if (is_rd) begin
                        n_rd_open[r_pipe] = 1'b0;
                    end else begin
                        n_wr_open[r_pipe] = 1'b0;
                    end
                end else begin
                    n_status = mcpf_pkg::STAT_NO_END;
                end
            end
            mcpf_pkg::MODE_WRITE: begin
                if (!usable) begin
                    n_status = mcpf_pkg::STAT_NO_END;
                end else if (is_rd) begin
                    n_status = mcpf_pkg::STAT_WRONG_DIR;
                end else if (r_cur_fill == FW'(RING_DEPTH)) begin
                    n_status = mcpf_pkg::STAT_BLOCK;
                end else begin
                    do_write = 1'b1;
                end
            end
            default: begin
                if (!usable) begin
                    n_status = mcpf_pkg::STAT_NO_END;
                end else if (!is_rd) begin
                    n_status = mcpf_pkg::STAT_WRONG_DIR;
                end else if (r_cur_fill == '0) begin
                    n_status = mcpf_pkg::STAT_BLOCK;
                end else begin
                    do_read = 1'b1;
                    n_rdata = r_mem_q;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_open <= '0;
            r_wr_open <= '0;
            r_created <= '0;
        end else if (i_cmd.commit) begin
            r_rd_open <= n_rd_open;
            r_wr_open <= n_wr_open;
            r_created <= n_created;
        end
    end

    // per-pipe pointers and fill levels
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_open) begin
            r_rd_ptr[open_idx] <= '0;
            r_wr_ptr[open_idx] <= '0;
            r_fill[open_idx]   <= '0;
        end else if (i_cmd.commit && do_write) begin
            r_wr_ptr[r_pipe] <= wr_next;
            r_fill[r_pipe]   <= r_cur_fill + FW'(1);
        end else if (i_cmd.commit && do_read) begin
            r_rd_ptr[r_pipe] <= rd_next;
            r_fill[r_pipe]   <= r_cur_fill - FW'(1);
        end
    end

    // ring memory, read when a word is taken in, written at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_write) begin
            r_ring[AW'({r_pipe, r_cur_wr})] <= r_byte;
        end
        if (i_cmd.load) begin
            r_mem_q <= r_ring[AW'({in_pipe, r_rd_ptr[in_pipe]})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= mcpf_pkg::t_mode'(i_mode);
            r_id       <= i_id;
            r_byte     <= i_byte;
            r_last     <= i_last;
            r_pipe     <= in_pipe;
            r_cur_rd   <= r_rd_ptr[in_pipe];
            r_cur_wr   <= r_wr_ptr[in_pipe];
            r_cur_fill <= r_fill[in_pipe];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_rdata  <= n_rdata;
            r_out_rid    <= n_rid;
            r_out_wid    <= n_wid;
            r_out_last   <= r_last;
        end
    end

    assign o_status = r_out_status;
    assign o_rdata  = r_out_rdata;
    assign o_rid    = r_out_rid;
    assign o_wid    = r_out_wid;
    assign o_last   = r_out_last;

    `MCPF_ASSERT(a_created_bound, r_created <= CNT_W'(NP))
    `MCPF_ASSERT(a_no_load_commit, !(i_cmd.load && i_cmd.commit))

endmodule

`default_nettype wire

[hw/rtl/multi_channel_pipe_fifo_unit.sv]
// top level of the multi-channel pipe fifo unit
// depends on mcpf_pkg, mcpf_ctrl and mcpf_dp
`default_nettype none

// Eight byte pipes, each with its own ring of RING_DEPTH bytes. Every input word
// (open, close, write byte, read byte) gives exactly one result word. Each word is
// first captured, with the pipe's pointers and ring byte fetched; then the pipe
// table and ring are updated and the result register is loaded. The unit works on
// one word at a time; it takes a new word while the previous result still waits
// in the output register, and stays in the update cycle while that register is
// full and not being taken. No clearing pass follows reset.

module multi_channel_pipe_fifo_unit #(
    parameter int RING_DEPTH = mcpf_pkg::RING_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // endpoint_id[3:0], data_byte[11:4], zero pad
    input  wire  [1:0]  s_axis_tuser,   // mode[1:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_data[7:0], read_end_id[10:8], write_end_id[14:11]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    mcpf_pkg::t_cmd                  cmd;
    logic [7:0]                      rdata;
    logic [mcpf_pkg::RID_W-1:0]      rid;
    logic [mcpf_pkg::ID_W-1:0]       wid;

    mcpf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    mcpf_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_mode   (s_axis_tuser),
        .i_id     (s_axis_tdata[3:0]),
        .i_byte   (s_axis_tdata[11:4]),
        .i_last   (s_axis_tlast),
        .o_status (m_axis_tuser),
        .o_rdata  (rdata),
        .o_rid    (rid),
        .o_wid    (wid),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, wid, rid, rdata};

endmodule

`default_nettype wire
